### rtl/core/cond_arith_register_alu_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the conditional arithmetic unit
// Shared concurrent check forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COND_ARITH_REGISTER_ALU_UNIT_DEFINES_SVH
`define COND_ARITH_REGISTER_ALU_UNIT_DEFINES_SVH

// implication checked every clock outside reset
`define CA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked every clock outside reset
`define CA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/caalu_pkg.sv
// ----------------------------------------------------------------------------
// caalu_pkg
// Types, opcodes and helpers for the conditional arithmetic unit.
// ----------------------------------------------------------------------------
package caalu_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned NumRegs   = 16;
  localparam int unsigned RegIdxW   = 4;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_ADC = 4'd1, OP_SUB = 4'd2, OP_SBC = 4'd3,
    OP_RSB = 4'd4, OP_RSC = 4'd5, OP_MUL = 4'd6, OP_MLA = 4'd7,
    OP_LDR = 4'd8, OP_LDF = 4'd9
  } op_t;

  typedef enum logic [3:0] {
    CC_EQ = 4'd0, CC_NE = 4'd1, CC_CS = 4'd2, CC_CC = 4'd3,
    CC_MI = 4'd4, CC_PL = 4'd5, CC_VS = 4'd6, CC_VC = 4'd7,
    CC_HI = 4'd8, CC_LS = 4'd9, CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } cc_t;

  // classified instruction passed from front to back
  typedef struct packed {
    logic              is_alu;   // modes 0..7
    logic              is_ldr;
    logic              is_ldf;
    logic [3:0]        mode;
    logic [3:0]        cond;
    logic              sbit;
    logic [3:0]        dest;
    logic [3:0]        rn;       // first operand register (subtrahend for rsb/rsc) / mla addend register
    logic [3:0]        rm;
    logic [3:0]        rs;
    logic [11:0]       imm;
    logic [31:0]       load;
  } uop_t;

  typedef struct packed {
    logic        executed;
    logic [3:0]  dest_index;
    logic [31:0] result_value;
    logic [3:0]  flags_after;
  } res_t;

  function automatic logic cond_pass(input logic [3:0] code, input logic [3:0] f);
    logic n, z, c, v;
    n = f[3]; z = f[2]; c = f[1]; v = f[0];
    unique case (code)
      CC_EQ: cond_pass = z;
      CC_NE: cond_pass = !z;
      CC_CS: cond_pass = c;
      CC_CC: cond_pass = !c;
      CC_MI: cond_pass = n;
      CC_PL: cond_pass = !n;
      CC_VS: cond_pass = v;
      CC_VC: cond_pass = !v;
      CC_HI: cond_pass = c && !z;
      CC_LS: cond_pass = !c || z;
      CC_GE: cond_pass = (n == v);
      CC_LT: cond_pass = (n != v);
      CC_GT: cond_pass = !z && (n == v);
      CC_LE: cond_pass = z || (n != v);
      CC_AL: cond_pass = 1'b1;
      default: cond_pass = 1'b0;
    endcase
  endfunction

endpackage

### rtl/core/cond_arith_register_alu_unit.sv
// ----------------------------------------------------------------------------
// cond_arith_register_alu_unit
// Conditional ALU with 16x32 register file, NZCV flags and multiply.
// ----------------------------------------------------------------------------
// One result beat per input beat, one beat per cycle sustained while the output
// is not stalled. An input beat is written into the two-entry queue at its
// accepting edge and later executed into the output register, where its result
// becomes valid. A stalled output holds the queue; once both entries are taken the
// input is held off until the output drains. The execute stage reads and
// writes the register file and flags in the same cycle, so back-to-back
// dependent instructions see each other's results.
module cond_arith_register_alu_unit #(
  parameter int unsigned QDepth = caalu_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // mode[3:0], instr_word[35:4], load_value[67:36]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // executed[0], dest_index[4:1], result_value[36:5],
                                 // flags_after[40:37]
);
  import caalu_pkg::*;

  logic push, full, pop, not_empty;
  uop_t push_uop, head;
  res_t m_res;

  caalu_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .mode(s_tdata[3:0]), .instr_word(s_tdata[35:4]), .load_value(s_tdata[67:36]),
    .push(push), .push_uop(push_uop), .q_full(full)
  );

  caalu_queue #(.Depth(QDepth)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_uop(push_uop), .full(full),
    .pop(pop), .not_empty(not_empty), .head(head)
  );

  caalu_back u_back (
    .clk(clk), .rst(rst), .not_empty(not_empty), .head(head), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(m_res)
  );

  assign m_tdata = {7'd0, m_res.flags_after, m_res.result_value,
                    m_res.dest_index, m_res.executed};

`include "cond_arith_register_alu_unit_defines.svh"

  `CA_ASSERT_IMP(a_no_push_full, full, !push, "push while queue full")
  `CA_ASSERT_NEXT(a_pop_valid, pop, m_tvalid, "popped op gave no result")
  `CA_ASSERT_IMP(a_skip_zero, m_tvalid && !m_tdata[0], m_tdata[36:5] == 32'd0, "nonzero result for skipped op")

endmodule

### rtl/core/caalu_front.sv
// ----------------------------------------------------------------------------
// caalu_front
// Decodes an input beat into a micro-op and pushes it into the queue.
// ----------------------------------------------------------------------------
module caalu_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [3:0]           mode,
  input  logic [31:0]          instr_word,
  input  logic [31:0]          load_value,
  output logic                 push,
  output caalu_pkg::uop_t      push_uop,
  input  logic                 q_full
);
  import caalu_pkg::*;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    push_uop.mode   = mode;
    push_uop.is_alu = (mode <= OP_MLA);
    push_uop.is_ldr = (mode == OP_LDR);
    push_uop.is_ldf = (mode == OP_LDF);
    push_uop.cond   = instr_word[31:28];
    push_uop.sbit   = instr_word[20];
    push_uop.rm     = instr_word[3:0];
    push_uop.rs     = instr_word[11:8];
    push_uop.imm    = instr_word[11:0];
    push_uop.load   = load_value;
    if (mode == OP_MUL || mode == OP_MLA) begin
      push_uop.dest = instr_word[19:16];
      push_uop.rn   = instr_word[15:12];
    end else begin
      push_uop.dest = (mode <= OP_LDR) ? instr_word[15:12] : 4'd0;
      push_uop.rn   = instr_word[19:16];
    end
  end

endmodule

### rtl/core/caalu_queue.sv
// ----------------------------------------------------------------------------
// caalu_queue
// Small FIFO of decoded micro-ops between front and back.
// ----------------------------------------------------------------------------
module caalu_queue #(
  parameter int unsigned Depth = caalu_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  caalu_pkg::uop_t push_uop,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output caalu_pkg::uop_t head
);
  import caalu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  uop_t             mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [PtrW:0]    count;

  assign full      = (count == (PtrW+1)'(Depth));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_uop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

### rtl/core/caalu_back.sv
// ----------------------------------------------------------------------------
// caalu_back
// Executes micro-ops against the register file and flags, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module caalu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  caalu_pkg::uop_t head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output caalu_pkg::res_t m_res
);
  import caalu_pkg::*;

  logic [31:0] regs [NumRegs];
  logic [NumRegs-1:0] written;   // cleared on reset, unwritten reads as zero
  logic [3:0]  flags;
  logic [3:0]  flags_next;
  logic [31:0] rn_v, rm_v, rs_v, res;
  logic [31:0] prod;
  logic        pass, wr_en, cin;

  assign pop = not_empty && (!m_tvalid || m_tready);

  assign rn_v = written[head.rn] ? regs[head.rn] : '0;
  assign rm_v = written[head.rm] ? regs[head.rm] : '0;
  assign rs_v = written[head.rs] ? regs[head.rs] : '0;
  assign cin  = flags[1];
  assign pass = cond_pass(head.cond, flags);
  assign prod = rm_v * rs_v;

  always_comb begin
    res = '0;
    unique case (head.mode)
      OP_ADD: res = rn_v + {20'd0, head.imm};
      OP_ADC: res = rn_v + rm_v + {31'd0, cin};
      OP_SUB: res = rn_v - {20'd0, head.imm};
      OP_SBC: res = rn_v - rm_v - {31'd0, !cin};
      OP_RSB: res = {20'd0, head.imm} - rn_v;
      OP_RSC: res = {20'd0, head.imm} - rn_v - {31'd0, !cin};
      OP_MUL: res = prod;
      OP_MLA: res = prod + rn_v;
      OP_LDR: res = head.load;
      default: res = '0;
    endcase
    wr_en = head.is_ldr || (head.is_alu && pass);
    flags_next = flags;
    if (head.is_ldf) flags_next = head.load[3:0];
    else if (head.is_alu && pass && head.sbit)
      flags_next = {res[31], (res == '0), flags[1:0]};
  end

  always_ff @(posedge clk) begin
    if (pop && wr_en) regs[head.dest] <= res;
    if (pop) begin
      m_res.executed     <= wr_en;
      m_res.dest_index   <= head.dest;
      m_res.result_value <= wr_en ? res : '0;
      m_res.flags_after  <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      flags    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop && wr_en) written[head.dest] <= 1'b1;
      if (pop) flags <= flags_next;
      if (pop) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule
